/* rtl/mp2a_pkg.sv */
package mp2a_pkg;

  localparam int unsigned DEF_MAX_KERNEL = 8;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned STEP_LIMIT     = 8;

  localparam logic [1:0] REG_KERNEL = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_LAST,
    ST_OUT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;       // write sample, latch window info
    logic scan_start; // first read issued this cycle
    logic scan_step;  // advance window read address
    logic cmp_en;     // read data valid, compare
    logic load_out;   // move result to output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fire;       // accepted sample completes a window
    logic scan_done;  // last window address issued
  } dp_stat_t;

  // strict IEEE single greater-than; NaN compares false
  function automatic logic fgt(input logic [31:0] a, input logic [31:0] b);
    logic an, bn, az;
    an = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    bn = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    az = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (an || bn || az) return 1'b0;
    if (!a[31] && !b[31]) return a[30:0] > b[30:0];
    if (a[31] && b[31]) return a[30:0] < b[30:0];
    return !a[31];
  endfunction

endpackage

/* rtl/mp2a_ctrl.sv */
module mp2a_ctrl import mp2a_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_free,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.take = 1'b1;
          if (stat.fire) state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // one store read per cycle; read data is registered and arrives in the next cycle
        cmd.scan_start = 1'b1;
        cmd.scan_step = 1'b1;
        state_next = stat.scan_done ? ST_LAST : ST_WAIT;
      end
      ST_WAIT: begin
        cmd.cmp_en = 1'b1;
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = ST_LAST;
      end
      ST_LAST: begin
        cmd.cmp_en = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/mp2a_dp.sv */
module mp2a_dp import mp2a_pkg::*; #(
  parameter int unsigned MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [31:0] sample,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  output logic [31:0] cfg_rdata,
  output logic        out_valid,
  input  logic        out_take,
  output logic [31:0] max_value,
  output logic [9:0]  max_row,
  output logic [9:0]  max_col,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic [15:0] plane_number,
  output logic        last_of_plane
);

  localparam int KW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int KB = $clog2(MAX_KERNEL + 1);
  localparam int DEPTH = MAX_KERNEL * (2 ** CW);
  localparam int AW = KW + CW;

  logic [3:0]  kernel_reg, step_reg;
  logic [10:0] width_reg, height_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_reg <= 4'd2;
      step_reg   <= 4'd2;
      width_reg  <= 11'd1024;
      height_reg <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_KERNEL: kernel_reg <= cfg_data[3:0];
        REG_STEP:   step_reg   <= cfg_data[3:0];
        REG_WIDTH:  width_reg  <= cfg_data[10:0];
        REG_HEIGHT: height_reg <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KERNEL: cfg_rdata = {28'd0, kernel_reg};
      REG_STEP:   cfg_rdata = {28'd0, step_reg};
      REG_WIDTH:  cfg_rdata = {21'd0, width_reg};
      default:    cfg_rdata = {21'd0, height_reg};
    endcase
  end

  // effective (clamped) settings
  logic [KB-1:0] k;
  logic [3:0]    s;
  logic [12:0]   w, h;
  always_comb begin
    if (kernel_reg == 4'd0) k = KB'(1);
    else if (32'(kernel_reg) > MAX_KERNEL) k = KB'(MAX_KERNEL);
    else k = KB'(kernel_reg);
    if (step_reg == 4'd0) s = 4'd1;
    else if (step_reg > 4'(STEP_LIMIT)) s = 4'(STEP_LIMIT);
    else s = step_reg;
    if (width_reg == 11'd0) w = 13'd1;
    else if (32'(width_reg) > MAX_WIDTH) w = 13'(MAX_WIDTH);
    else w = 13'(width_reg);
    if (height_reg == 11'd0) h = 13'd1;
    else if (32'(height_reg) > MAX_HEIGHT) h = 13'(MAX_HEIGHT);
    else h = 13'(height_reg);
  end

  // position; phase counters track (pos+1-k) mod s
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [KW-1:0] ring;
  logic [15:0]   plane;
  logic [3:0]    rph, cph;   // steps since last window row/col, valid once >= k-1
  logic [9:0]    orow, ocol;

  logic [12:0] r1, c1;
  logic row_ok, col_ok, fire, eol, eop;
  assign r1 = 13'(row) + 13'd1;
  assign c1 = 13'(col) + 13'd1;
  assign row_ok = (r1 >= 13'(k)) && (rph == 4'd0);
  assign col_ok = (c1 >= 13'(k)) && (cph == 4'd0);
  assign fire = row_ok && col_ok && (13'(k) <= h) && (13'(k) <= w);
  assign eol = c1 >= w;
  assign eop = r1 >= h;
  assign stat.fire = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0; col <= '0; ring <= '0; plane <= '0;
      rph <= '0; cph <= '0; orow <= '0; ocol <= '0;
    end else if (cfg_we) begin
      row <= '0; col <= '0; ring <= '0;
      rph <= '0; cph <= '0; orow <= '0; ocol <= '0;
    end else if (cmd.take) begin
      if (eol) begin
        col <= '0; cph <= '0; ocol <= '0;
        if (eop) begin
          row <= '0; ring <= '0; rph <= '0; orow <= '0;
          plane <= plane + 16'd1;
        end else begin
          row <= row + RW'(1);
          ring <= (32'(ring) == MAX_KERNEL - 1) ? '0 : ring + KW'(1);
          if (r1 >= 13'(k)) begin
            rph <= (rph + 4'd1 == s) ? 4'd0 : rph + 4'd1;
            if (row_ok) orow <= orow + 10'd1;
          end
        end
      end else begin
        col <= col + CW'(1);
        if (c1 >= 13'(k)) begin
          cph <= (cph + 4'd1 == s) ? 4'd0 : cph + 4'd1;
          if (col_ok) ocol <= ocol + 10'd1;
        end
      end
    end
  end

  // row store
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd;
  logic [AW-1:0] rd_addr;
  logic [KW-1:0] rslot;
  logic [CW-1:0] rcol;

  always_ff @(posedge clk) begin
    if (cmd.take) mem[{ring, col}] <= sample;
    rd <= mem[rd_addr];
  end

  // window latched at take
  logic [9:0]    w_top, w_left, w_orow, w_ocol;
  logic [15:0]   w_plane;
  logic          w_last;
  logic [KW-1:0] w_slot0;
  logic [KB-1:0] w_k;
  logic [KB-1:0] si, sj;
  logic [9:0]    pi, pj;   // coordinates of data in rd

  // sums stay below 2*MAX_KERNEL, so one conditional subtract wraps them
  logic [KW:0] slot0_sum;
  assign slot0_sum = (KW+1)'(ring) + (KW+1)'(MAX_KERNEL) - (KW+1)'(k - KB'(1));

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      w_top   <= 10'(r1 - 13'(k));
      w_left  <= 10'(c1 - 13'(k));
      w_orow  <= orow;
      w_ocol  <= ocol;
      w_plane <= plane;
      w_last  <= (r1 + 13'(s) > h) && (c1 + 13'(s) > w);
      w_slot0 <= (32'(slot0_sum) >= MAX_KERNEL) ? KW'(32'(slot0_sum) - MAX_KERNEL)
                                                 : KW'(slot0_sum);
      w_k     <= k;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      si <= '0; sj <= '0;
    end else if (cmd.scan_step) begin
      if (sj == w_k - KB'(1)) begin
        sj <= '0; si <= si + KB'(1);
      end else sj <= sj + KB'(1);
    end
  end

  logic [KW:0] slot_sum;
  assign slot_sum = (KW+1)'(w_slot0) + (KW+1)'(si);
  assign rslot = (32'(slot_sum) >= MAX_KERNEL) ? KW'(32'(slot_sum) - MAX_KERNEL)
                                                : KW'(slot_sum);
  assign rcol = CW'(w_left) + CW'(sj);
  assign rd_addr = {rslot, rcol};
  assign stat.scan_done = (si == w_k - KB'(1)) && (sj == w_k - KB'(1));

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      pi <= w_top + 10'(si);
      pj <= w_left + 10'(sj);
    end
  end

  logic [31:0] best;
  logic [9:0]  br, bc;
  logic        first;
  always_ff @(posedge clk) begin
    if (cmd.scan_start) first <= 1'b1;
    else if (cmd.cmp_en) first <= 1'b0;
    if (cmd.cmp_en && (first || fgt(rd, best))) begin
      best <= rd; br <= pi; bc <= pj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_take) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      max_value <= best; max_row <= br; max_col <= bc;
      out_row <= w_orow; out_col <= w_ocol;
      plane_number <= w_plane; last_of_plane <= w_last;
    end
  end

endmodule

/* rtl/max_pool_2d_argmax.sv */
// Max pooling with argmax over a stream of IEEE single image planes.
// Input: s_axis words carry one sample each, planes back to back in raster
// order. Output: m_axis words carry one result per completed window:
// maximum, its plane row/column, pooled row/column, plane number; tlast
// marks the final pooled result of a plane.
// Every sample is written to the row store. A sample that completes a
// kernel x kernel window also starts a scan: the window is read from the
// row store one entry per cycle over its single read port and compared
// serially, then placed in the output register; input waits meanwhile.
// The output register holds one result; the next window may be gathered
// while it waits, and the block stalls only when a second result is ready.
// Reset (synchronous, rst high) restores kernel 2, step 2, 1024 x 1024,
// clears the position and plane count; the row store is not cleared since
// windows only read samples of the current plane. Any register write
// restarts the position at row 0, column 0. Registers at 0x0 kernel,
// 0x4 step, 0x8 width, 0xC height; write only while idle.
module max_pool_2d_argmax import mp2a_pkg::*; #(
  parameter int unsigned MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // max_value[31:0], max_row[41:32], max_col[51:42], out_row[61:52],
  // out_col[71:62], plane_number[87:72]
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast,   // last_of_plane
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_valid, out_free, cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign out_free = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;

  mp2a_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_free(out_free), .stat(stat), .cmd(cmd)
  );

  mp2a_dp #(
    .MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .sample(s_axis_tdata),
    .cfg_we(cfg_we), .cfg_idx(paddr[3:2]), .cfg_data(pwdata), .cfg_rdata(prdata),
    .out_valid(out_valid), .out_take(m_axis_tready),
    .max_value(m_axis_tdata[31:0]), .max_row(m_axis_tdata[41:32]),
    .max_col(m_axis_tdata[51:42]), .out_row(m_axis_tdata[61:52]),
    .out_col(m_axis_tdata[71:62]), .plane_number(m_axis_tdata[87:72]),
    .last_of_plane(m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.cmp_en |-> !s_axis_tready) else $error("accepted during scan");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free) else $error("output overwritten");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_axis_tvalid) else $error("result lost");
`endif

endmodule
